// ----- hdl/xpg_pkg.sv -----
package xpg_pkg;

    // field widths
    localparam int unsigned WordWidth = 64;
    localparam int unsigned HalfWidth = 32;
    localparam int unsigned OpWidth   = 2;

    // splitmix64 constants
    localparam logic [63:0] SeedGamma = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SeedMulA  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SeedMulB  = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned SeedShiftIn  = 30;
    localparam int unsigned SeedShiftMid = 27;
    localparam int unsigned SeedShiftOut = 31;

    // xoshiro shift and rotate amounts
    localparam int unsigned Shift128  = 9;
    localparam int unsigned Rotate128 = 11;
    localparam int unsigned Shift256  = 17;
    localparam int unsigned Rotate256 = 45;

    // width mode after reset: 64-bit words
    localparam logic ModeReset = 1'b1;

    // operation codes carried in tuser
    typedef enum logic [OpWidth-1:0] {
        OP_NEXT   = 2'd0,
        OP_RESEED = 2'd1,
        OP_LOAD   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MIX,
        ST_STORE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic next_value;   // advance generator, load output register
        logic load_seed;    // seeder counter takes tdata
        logic seed_step;    // counter += gamma, z = first mix
        logic mul_clear;    // acc = partial product
        logic mul_accum;    // acc += partial product << 32
        logic mul_z_hi;     // multiplicand takes upper half of z
        logic mul_k_hi;     // multiplier takes upper half of constant
        logic k_second;     // second splitmix constant
        logic mix;          // z = acc ^ (acc >> shift)
        logic mix_last;     // use the final shift amount
        logic store;        // write z into a word pair
        logic store_upper;  // words 2 and 3 instead of 0 and 1
    } cmd_t;

endpackage

// ----- hdl/xpg_ctrl.sv -----
module xpg_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [xpg_pkg::OpWidth-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output xpg_pkg::cmd_t               cmd
);

    xpg_pkg::state_t state_reg, state_next;
    logic            draw_reg, draw_next;
    logic            round_reg, round_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;

    // ready when idle and the output slot is free or draining
    assign s_tready = (state_reg == xpg_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= xpg_pkg::ST_IDLE;
            draw_reg      <= 1'b0;
            round_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            draw_reg      <= draw_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        draw_next  = draw_reg;
        round_next = round_reg;
        cmd        = '0;
        cmd.k_second    = round_reg;
        cmd.mix_last    = round_reg;
        cmd.store_upper = draw_reg;
        case (state_reg)
            xpg_pkg::ST_IDLE: begin
                if (accept) begin
                    case (xpg_pkg::op_t'(s_tuser))
                        xpg_pkg::OP_NEXT: begin
                            cmd.next_value = 1'b1;
                        end
                        xpg_pkg::OP_RESEED: begin
                            draw_next  = 1'b0;
                            state_next = xpg_pkg::ST_SEED;
                        end
                        xpg_pkg::OP_LOAD: begin
                            cmd.load_seed = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            xpg_pkg::ST_SEED: begin
                cmd.seed_step = 1'b1;
                round_next    = 1'b0;
                state_next    = xpg_pkg::ST_MUL0;
            end
            xpg_pkg::ST_MUL0: begin
                cmd.mul_clear = 1'b1;
                state_next    = xpg_pkg::ST_MUL1;
            end
            xpg_pkg::ST_MUL1: begin
                cmd.mul_accum = 1'b1;
                cmd.mul_k_hi  = 1'b1;
                state_next    = xpg_pkg::ST_MUL2;
            end
            xpg_pkg::ST_MUL2: begin
                cmd.mul_accum = 1'b1;
                cmd.mul_z_hi  = 1'b1;
                state_next    = xpg_pkg::ST_MIX;
            end
            xpg_pkg::ST_MIX: begin
                cmd.mix = 1'b1;
                if (round_reg) begin
                    state_next = xpg_pkg::ST_STORE;
                end else begin
                    round_next = 1'b1;
                    state_next = xpg_pkg::ST_MUL0;
                end
            end
            xpg_pkg::ST_STORE: begin
                cmd.store = 1'b1;
                if (draw_reg) begin
                    state_next = xpg_pkg::ST_IDLE;
                end else begin
                    draw_next  = 1'b1;
                    state_next = xpg_pkg::ST_SEED;
                end
            end
            default: begin
                state_next = xpg_pkg::ST_IDLE;
            end
        endcase
    end

    // output slot: filled by a next transfer, emptied by the receiver
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.next_value) begin
            out_valid_next = 1'b1;
        end
    end

endmodule

// ----- hdl/xpg_datapath.sv -----
module xpg_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic [xpg_pkg::WordWidth-1:0] s_tdata,
    output logic [xpg_pkg::WordWidth-1:0] m_tdata,
    input  xpg_pkg::cmd_t                 cmd
);

    localparam int unsigned W = xpg_pkg::WordWidth;
    localparam int unsigned H = xpg_pkg::HalfWidth;

    logic         mode_reg;
    logic [W-1:0] words_reg [4];
    logic [W-1:0] words_next [4];
    logic [W-1:0] counter_reg, counter_next;
    logic [W-1:0] z_reg, z_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] out_reg;

    logic [W-1:0] gen_sum;
    logic [W-1:0] adv [4];
    logic [W-1:0] seeded;
    logic [W-1:0] k_word;
    logic [H-1:0] op_a, op_b;
    logic [W-1:0] prod;
    logic [W-1:0] mixed;

    // xoshiro step in both widths
    always_comb begin
        logic [W-1:0] t64, a2, a3, a1, a0;
        logic [H-1:0] t32, b2, b3, b1, b0, w0, w1, w2, w3;
        w0  = words_reg[0][H-1:0];
        w1  = words_reg[1][H-1:0];
        w2  = words_reg[2][H-1:0];
        w3  = words_reg[3][H-1:0];
        t64 = words_reg[1] << xpg_pkg::Shift256;
        a2  = words_reg[2] ^ words_reg[0];
        a3  = words_reg[3] ^ words_reg[1];
        a1  = words_reg[1] ^ a2;
        a0  = words_reg[0] ^ a3;
        t32 = w1 << xpg_pkg::Shift128;
        b2  = w2 ^ w0;
        b3  = w3 ^ w1;
        b1  = w1 ^ b2;
        b0  = w0 ^ b3;
        if (mode_reg) begin
            gen_sum = words_reg[0] + words_reg[3];
            adv[0]  = a0;
            adv[1]  = a1;
            adv[2]  = a2 ^ t64;
            adv[3]  = (a3 << xpg_pkg::Rotate256) | (a3 >> (W - xpg_pkg::Rotate256));
        end else begin
            gen_sum = {{(W-H){1'b0}}, w0 + w3};
            adv[0]  = {{(W-H){1'b0}}, b0};
            adv[1]  = {{(W-H){1'b0}}, b1};
            adv[2]  = {{(W-H){1'b0}}, b2 ^ t32};
            adv[3]  = {{(W-H){1'b0}},
                       (b3 << xpg_pkg::Rotate128) | (b3 >> (H - xpg_pkg::Rotate128))};
        end
    end

    // splitmix64: counter step, one 32x32 partial product, xor-shift mix
    assign seeded = counter_reg + xpg_pkg::SeedGamma;
    assign k_word = cmd.k_second ? xpg_pkg::SeedMulB : xpg_pkg::SeedMulA;
    assign op_a   = cmd.mul_z_hi ? z_reg[W-1:H] : z_reg[H-1:0];
    assign op_b   = cmd.mul_k_hi ? k_word[W-1:H] : k_word[H-1:0];
    assign prod   = {{(W-H){1'b0}}, op_a} * {{(W-H){1'b0}}, op_b};
    assign mixed  = cmd.mix_last ? (acc_reg ^ (acc_reg >> xpg_pkg::SeedShiftOut))
                                 : (acc_reg ^ (acc_reg >> xpg_pkg::SeedShiftMid));

    // next values of the seeder and generator state
    always_comb begin
        counter_next = counter_reg;
        z_next       = z_reg;
        acc_next     = acc_reg;
        for (int i = 0; i < 4; i++) begin
            words_next[i] = words_reg[i];
        end
        if (cmd.load_seed) begin
            counter_next = s_tdata;
        end
        if (cmd.seed_step) begin
            counter_next = seeded;
            z_next       = seeded ^ (seeded >> xpg_pkg::SeedShiftIn);
        end
        if (cmd.mul_clear) begin
            acc_next = prod;
        end
        if (cmd.mul_accum) begin
            acc_next = acc_reg + {prod[H-1:0], {H{1'b0}}};
        end
        if (cmd.mix) begin
            z_next = mixed;
        end
        if (cmd.next_value) begin
            for (int i = 0; i < 4; i++) begin
                words_next[i] = adv[i];
            end
        end
        if (cmd.store) begin
            if (cmd.store_upper) begin
                words_next[2] = {{(W-H){1'b0}}, z_reg[H-1:0]};
                words_next[3] = {{(W-H){1'b0}}, z_reg[W-1:H]};
            end else begin
                words_next[0] = {{(W-H){1'b0}}, z_reg[H-1:0]};
                words_next[1] = {{(W-H){1'b0}}, z_reg[W-1:H]};
            end
        end
    end

    // generator and seeder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= xpg_pkg::ModeReset;
            counter_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                words_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            counter_reg <= counter_next;
            for (int i = 0; i < 4; i++) begin
                words_reg[i] <= words_next[i];
            end
        end
    end

    // working registers and output register
    always_ff @(posedge aclk) begin
        z_reg   <= z_next;
        acc_reg <= acc_next;
        if (cmd.next_value) begin
            out_reg <= gen_sum;
        end
    end

    assign m_tdata = out_reg;

endmodule

// ----- hdl/xoshiro_plus_generator.sv -----
// xoshiro_plus_generator: xoshiro128+ / xoshiro256+ source with a splitmix64 seeder.
// Input channel s_*: tuser carries the operation (next, reseed, load seeder, none),
// tdata carries the seeder value for a load. Output channel m_*: one 64-bit
// value per next transfer; in 32-bit mode the upper half is zero.
// cfg_wr_en/cfg_wr_data write the width mode (0 = 32-bit words, 1 = 64-bit words);
// write it only while the block is idle.
// A next transfer shows its value on m_tdata in the cycle after its acceptance.
// Next, load and no-op transfers leave the controller idle, so back to back
// next transfers give one value per cycle while the receiver keeps up.
// A reseed occupies the controller after acceptance for two splitmix64
// draws, each a counter step, two 64-bit constant multiplies built from three
// 32x32 partial products on one shared multiplier, two mix steps and a store.
// Reset (aresetn low, synchronous) clears the words and the seeder counter and
// selects 64-bit mode. When the receiver stalls, the value is held in the output
// register and s_tready drops until that value is taken.
module xoshiro_plus_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] seed_value
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // [63:0] random_value
);

    xpg_pkg::cmd_t cmd;

    // sequencer
    xpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // generator, seeder and output register
    xpg_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .cmd         (cmd)
    );

endmodule

// ----- hdl/xpg_checker.sv -----
module xpg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // stalled output holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

    // nothing is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // a next transfer gives a result in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == xpg_pkg::OP_NEXT |=> m_tvalid)
        else $error("next transfer gave no result");

    // other operations give no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != xpg_pkg::OP_NEXT && (!m_tvalid || m_tready)
        |=> !m_tvalid)
        else $error("result without a next transfer");

    // a reseed keeps the input closed while it runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == xpg_pkg::OP_RESEED |=> !s_tready)
        else $error("input open during reseed");

endmodule

bind xoshiro_plus_generator xpg_checker u_xpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit   = 1_000_000;
    localparam int unsigned SettleCycles = 30;   // idle wait long enough for a running reseed to finish
    localparam int unsigned PhaseCount   = 6;
    localparam int unsigned PhaseItems   = 255;
    localparam int unsigned DirRows      = 26;
    localparam logic [63:0] AllOnes      = 64'hFFFF_FFFF_FFFF_FFFF;

    // one row of the directed table: optional mode write before the transfer
    typedef struct packed {
        logic         set_mode;
        logic         mode_val;
        xpg_pkg::op_t op;
        logic [63:0]  seed;
        logic         known;
        logic [63:0]  value;
    } stim_row_t;

    // rows with known set carry the value typed in; all others use the predictor
    stim_row_t directed [DirRows] = '{
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b1, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NONE,   AllOnes,                 1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   AllOnes,                 1'b1, 64'd0},
        '{1'b1, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b1, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_LOAD,   AllOnes,                 1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_RESEED, 64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   AllOnes,                 1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b1, 1'b1, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_LOAD,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_RESEED, AllOnes,                 1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NONE,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b1, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_LOAD,   64'h8000_0000_0000_0001, 1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_RESEED, 64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_RESEED, 64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0},
        '{1'b1, 1'b1, xpg_pkg::OP_LOAD,   64'h5555_5555_AAAA_AAAA, 1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_RESEED, 64'd0,                   1'b0, 64'd0},
        '{1'b0, 1'b0, xpg_pkg::OP_NEXT,   64'd0,                   1'b0, 64'd0}
    };

    // per phase: width mode, sender idle percentage, receiver stall percentage
    logic        phase_mode  [PhaseCount] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    int unsigned phase_gap   [PhaseCount] = '{0, 25, 50, 10, 30, 0};
    int unsigned phase_stall [PhaseCount] = '{0, 30, 10, 50, 0, 25};

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata     = 64'd0;
    logic [1:0]  s_tuser     = xpg_pkg::OP_NONE;    // [1:0] op
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [63:0] m_tdata;

    // predictor state
    logic [63:0] gen_word [4];
    logic [63:0] seed_ctr;
    logic        mode_now;

    logic [63:0] expected_values [$];
    logic [63:0] want;

    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 20;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;
    int unsigned items_sent  = 0;
    int unsigned values_seen = 0;
    int unsigned reseeds     = 0;
    int unsigned loads       = 0;
    int unsigned mode_writes = 0;

    xoshiro_plus_generator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // one splitmix64 output, advancing the seeder counter
    function automatic logic [63:0] splitmix_draw();
        logic [63:0] z;
        seed_ctr = seed_ctr + xpg_pkg::SeedGamma;
        z = seed_ctr;
        z = (z ^ (z >> xpg_pkg::SeedShiftIn)) * xpg_pkg::SeedMulA;
        z = (z ^ (z >> xpg_pkg::SeedShiftMid)) * xpg_pkg::SeedMulB;
        return z ^ (z >> xpg_pkg::SeedShiftOut);
    endfunction

    // xoshiro+ output and state advance at the current width
    function automatic logic [63:0] xoshiro_advance();
        logic [31:0] h0, h1, h2, h3, hs, ht;
        logic [63:0] w0, w1, w2, w3, ws, wt;
        if (!mode_now) begin
            h0 = gen_word[0][31:0];
            h1 = gen_word[1][31:0];
            h2 = gen_word[2][31:0];
            h3 = gen_word[3][31:0];
            hs = h0 + h3;
            ht = h1 << xpg_pkg::Shift128;
            h2 = h2 ^ h0;
            h3 = h3 ^ h1;
            h1 = h1 ^ h2;
            h0 = h0 ^ h3;
            h2 = h2 ^ ht;
            h3 = (h3 << xpg_pkg::Rotate128)
               | (h3 >> (xpg_pkg::HalfWidth - xpg_pkg::Rotate128));
            gen_word[0] = {32'd0, h0};
            gen_word[1] = {32'd0, h1};
            gen_word[2] = {32'd0, h2};
            gen_word[3] = {32'd0, h3};
            return {32'd0, hs};
        end
        w0 = gen_word[0];
        w1 = gen_word[1];
        w2 = gen_word[2];
        w3 = gen_word[3];
        ws = w0 + w3;
        wt = w1 << xpg_pkg::Shift256;
        w2 = w2 ^ w0;
        w3 = w3 ^ w1;
        w1 = w1 ^ w2;
        w0 = w0 ^ w3;
        w2 = w2 ^ wt;
        w3 = (w3 << xpg_pkg::Rotate256) | (w3 >> (xpg_pkg::WordWidth - xpg_pkg::Rotate256));
        gen_word[0] = w0;
        gen_word[1] = w1;
        gen_word[2] = w2;
        gen_word[3] = w3;
        return ws;
    endfunction

    // update the predictor for one accepted input transfer
    task automatic apply_op(input xpg_pkg::op_t op, input logic [63:0] seed,
                            input logic known, input logic [63:0] value);
        logic [63:0] out_value, a, b;
        case (op)
            xpg_pkg::OP_NEXT: begin
                out_value = xoshiro_advance();
                expected_values.push_back(known ? value : out_value);
            end
            xpg_pkg::OP_RESEED: begin
                a = splitmix_draw();
                b = splitmix_draw();
                gen_word[0] = {32'd0, a[31:0]};
                gen_word[1] = {32'd0, a[63:32]};
                gen_word[2] = {32'd0, b[31:0]};
                gen_word[3] = {32'd0, b[63:32]};
                reseeds++;
            end
            xpg_pkg::OP_LOAD: begin
                seed_ctr = seed;
                loads++;
            end
            default: ;
        endcase
    endtask

    // drive one input transfer and wait for its acceptance
    task automatic send_item(input xpg_pkg::op_t op, input logic [63:0] seed,
                             input logic known, input logic [63:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        apply_op(op, seed, known, value);
    endtask

    task automatic wait_drained();
        while (expected_values.size() != 0)
            @(posedge aclk);
    endtask

    // width mode write, only with the block idle
    task automatic write_mode(input logic m);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SettleCycles) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_now = m;
        mode_writes++;
    endtask

    // output side: check every transfer, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                $error("random_value: no value expected, got %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_values.pop_front();
                values_seen++;
                if (m_tdata !== want) begin
                    $error("random_value: expected %h, actual %h", want, m_tdata);
                    fail_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // stimulus
    initial begin
        int unsigned  idx, phase, counted, pick;
        xpg_pkg::op_t op;
        logic [63:0]  seed;

        foreach (gen_word[i])
            gen_word[i] = 64'd0;
        seed_ctr = 64'd0;
        mode_now = xpg_pkg::ModeReset;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, back to back
        for (idx = 0; idx < DirRows; idx++) begin
            if (directed[idx].set_mode)
                write_mode(directed[idx].mode_val);
            send_item(directed[idx].op, directed[idx].seed,
                      directed[idx].known, directed[idx].value);
        end

        // random phases, mostly next values between loads and reseeds
        for (phase = 0; phase < PhaseCount; phase++) begin
            write_mode(phase_mode[phase]);
            gap_pct   = phase_gap[phase];
            stall_pct = phase_stall[phase];
            counted   = 0;
            while (counted < PhaseItems) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    op = xpg_pkg::OP_NEXT;
                else if (pick < 80)
                    op = xpg_pkg::OP_RESEED;
                else if (pick < 92)
                    op = xpg_pkg::OP_LOAD;
                else
                    op = xpg_pkg::OP_NONE;
                case ($urandom_range(0, 7))
                    0:       seed = 64'd0;
                    1:       seed = AllOnes;
                    default: seed = {$urandom, $urandom};
                endcase
                // now and then hold off until the output side has caught up, else idle for a random gap at gap_pct
                if ($urandom_range(0, 149) == 0) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                    @(posedge aclk);
                end else if ($urandom_range(0, 99) < gap_pct) begin
                    s_tvalid <= 1'b0;
                    repeat (pick_gap()) @(posedge aclk);
                end
                send_item(op, seed, 1'b0, 64'd0);
                counted++;
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SettleCycles) @(posedge aclk);

        $display("covered %0d input transfers (%0d reseeds, %0d seeder loads), %0d values checked",
                 items_sent, reseeds, loads, values_seen);
        $display("width mode written %0d times, both 32-bit and 64-bit generators exercised",
                 mode_writes);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
